FILE: design/irsa_pkg.sv
// Shared types, codes, constants and helper functions of the integer RPN stack ALU.
package irsa_pkg;

    localparam int DATA_W = 64;
    localparam int OP_W   = 5;
    localparam int SLOT_W = 2;
    localparam int ST_W   = 3;
    localparam int WC_W   = 2;
    localparam int IN_W   = 72;

    localparam logic [WC_W-1:0]   WC_RESET  = 2'd3;
    localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd2;

    // Operation codes carried in the low bits of the input word.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 5'd0,
        OP_ADD    = 5'd1,
        OP_SUB    = 5'd2,
        OP_MUL    = 5'd3,
        OP_DIV    = 5'd4,
        OP_REM    = 5'd5,
        OP_SHR    = 5'd6,
        OP_SHL    = 5'd7,
        OP_AND    = 5'd8,
        OP_OR     = 5'd9,
        OP_XOR    = 5'd10,
        OP_NOT    = 5'd11,
        OP_NEG    = 5'd12,
        OP_RECIP  = 5'd13,
        OP_SQRT   = 5'd14,
        OP_FRAC   = 5'd15,
        OP_INT    = 5'd16,
        OP_CLEAR  = 5'd17,
        OP_DROP   = 5'd18,
        OP_DUP    = 5'd19,
        OP_LASTX  = 5'd20,
        OP_SWAP   = 5'd21,
        OP_STORE  = 5'd22,
        OP_RECALL = 5'd23
    } t_op;

    // Status codes reported with every result word.
    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_FEW     = 3'd1,
        ST_DIV0    = 3'd2,
        ST_NEGROOT = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // Modes of the multi-cycle arithmetic unit.
    typedef enum logic [1:0] {
        IM_MUL  = 2'd0,
        IM_DIV  = 2'd1,
        IM_SQRT = 2'd2
    } t_imode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd_second;
        logic cap_x;
        logic cap_y;
        logic oper;
        logic iter_latch;
        logic commit;
        logic swap2;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_iter;
        logic iter_done;
        logic out_free;
        logic swap_ok;
    } t_dp_sts;

    // Mask a word to the selected width and sign-extend it back to 64 bits.
    function automatic logic [DATA_W-1:0] sx(input logic [DATA_W-1:0] v,
                                             input logic [WC_W-1:0] code);
        logic [DATA_W-1:0] r;
        case (code)
            2'd0:    r = {{56{v[7]}}, v[7:0]};
            2'd1:    r = {{48{v[15]}}, v[15:0]};
            2'd2:    r = {{32{v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    // Word width in bits for a width code.
    function automatic logic [6:0] width_bits(input logic [WC_W-1:0] code);
        return 7'd8 << code;
    endfunction

endpackage

FILE: design/integer_rpn_stack_alu.sv
// Integer RPN stack calculator: top level joining the controller and the datapath.
// Each input word carries one operation and returns exactly one result word with the new
// top of stack, the depth and a status. An item is accepted, executed and written back;
// swap adds a second write, and multiply, divide and square root iterate in the shared
// multi-cycle unit, one quotient, product or root bit per cycle. Stack operands are
// fetched one per cycle through the single read port of the stack memory. The next
// item is accepted once the current one is written back; a result word may still wait
// at the output. Write the width register only while idle; the block does not enforce it.
module integer_rpn_stack_alu import irsa_pkg::*; #(
    parameter int STACK_ENTRIES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [WC_W-1:0]     i_cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // operation[4:0], value[68:5], slot[70:69], zero pad
    input  logic [IN_W-1:0]     s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // top_value[63:0], depth[DW+63:64], status[DW+66:DW+64], zero pad
    output logic [((DATA_W+$clog2(STACK_ENTRIES+1)+ST_W+7)/8)*8-1:0] m_tdata
);

    localparam int DW    = $clog2(STACK_ENTRIES + 1);
    localparam int OUT_W = ((DATA_W + DW + ST_W + 7) / 8) * 8;

    t_ctl_cmd          cmd;
    t_dp_sts           sts;
    logic [DATA_W-1:0] top;
    logic [DW-1:0]     depth;
    logic [ST_W-1:0]   status;

    irsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    irsa_dp #(
        .STACK_ENTRIES (STACK_ENTRIES),
        .DW            (DW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_tdata),
        .i_m_tready  (m_tready),
        .o_m_tvalid  (m_tvalid),
        .o_top       (top),
        .o_depth     (depth),
        .o_status    (status),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    assign m_tdata = OUT_W'({status, depth, top});

endmodule

FILE: design/irsa_ctrl.sv
// Controller state machine that sequences reads, execution, iteration and write-back.
module irsa_ctrl import irsa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_sts  i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_GETX   = 7'b0000010,
        S_GETY   = 7'b0000100,
        S_OPER   = 7'b0001000,
        S_ITER   = 7'b0010000,
        S_COMMIT = 7'b0100000,
        S_SWAP2  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_GETX;
                end
            end
            S_GETX: begin
                o_cmd.cap_x     = 1'b1;
                o_cmd.rd_second = 1'b1;
                n_state         = S_GETY;
            end
            S_GETY: begin
                o_cmd.cap_y = 1'b1;
                n_state     = S_OPER;
            end
            S_OPER: begin
                o_cmd.oper = 1'b1;
                n_state    = i_sts.need_iter ? S_ITER : S_COMMIT;
            end
            S_ITER: begin
                if (i_sts.iter_done) begin
                    o_cmd.iter_latch = 1'b1;
                    n_state          = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = i_sts.swap_ok ? S_SWAP2 : S_IDLE;
                end
            end
            S_SWAP2: begin
                o_cmd.swap2 = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/irsa_iter.sv
// Multi-cycle unit: shift-add multiply, restoring divide and digit-by-digit square root.
module irsa_iter import irsa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_imode            i_mode,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quo,
    output logic [DATA_W-1:0] o_rem
);

    logic              r_busy, r_done;
    logic [5:0]        r_cnt;
    t_imode            r_mode;
    logic [DATA_W-1:0] r_acc, r_opa, r_opb, r_rem;

    logic [DATA_W:0]   div_sh;
    logic              div_ge;
    logic [35:0]       sq_rem, sq_trial;
    logic              sq_ge;

    // One step of each algorithm.
    always_comb begin
        div_sh   = {r_rem, r_opa[DATA_W-1]};
        div_ge   = div_sh >= {1'b0, r_opb};
        sq_rem   = {r_rem[33:0], r_opa[DATA_W-1:DATA_W-2]};
        sq_trial = {2'b00, r_acc[31:0], 2'b01};
        sq_ge    = sq_rem >= sq_trial;
    end

    // Control: step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_mode == IM_SQRT) ? 6'd31 : 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mode <= i_mode;
            r_acc  <= '0;
            r_opa  <= i_a;
            r_opb  <= i_b;
            r_rem  <= '0;
        end else if (r_busy) begin
            case (r_mode)
                IM_MUL: begin
                    if (r_opb[0]) begin
                        r_acc <= r_acc + r_opa;
                    end
                    r_opa <= r_opa << 1;
                    r_opb <= r_opb >> 1;
                end
                IM_DIV: begin
                    r_opa <= {r_opa[DATA_W-2:0], div_ge};
                    r_rem <= div_ge ? DATA_W'(div_sh - {1'b0, r_opb}) : div_sh[DATA_W-1:0];
                end
                default: begin
                    r_opa <= r_opa << 2;
                    r_acc <= {32'd0, r_acc[30:0], sq_ge};
                    r_rem <= {28'd0, sq_ge ? (sq_rem - sq_trial) : sq_rem};
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_comb begin
        case (r_mode)
            IM_MUL:  o_quo = r_acc;
            IM_DIV:  o_quo = r_opa;
            default: o_quo = {32'd0, r_acc[31:0]};
        endcase
    end

endmodule

FILE: design/irsa_dp.sv
// Datapath: operand stack memory, registers, operation logic and the output word register.
module irsa_dp import irsa_pkg::*; #(
    parameter int STACK_ENTRIES = 32,
    parameter int DW = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WC_W-1:0]   i_cfg_wdata,
    input  logic [IN_W-1:0]   i_s_tdata,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [DATA_W-1:0] o_top,
    output logic [DW-1:0]     o_depth,
    output logic [ST_W-1:0]   o_status,
    input  t_ctl_cmd          i_cmd,
    output t_dp_sts           o_sts
);

    localparam int AW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

    logic [DATA_W-1:0] r_mem [STACK_ENTRIES];
    logic [DATA_W-1:0] r_rdata;

    logic [WC_W-1:0]   r_wcode;
    logic [DW-1:0]     r_depth;
    logic [DATA_W-1:0] r_last_x;
    logic [DATA_W-1:0] r_saved [3];
    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_val;
    logic [SLOT_W-1:0] r_slot;
    logic [DATA_W-1:0] r_x, r_y, r_res;
    t_status           r_st;
    logic              r_qneg, r_rneg;
    logic              r_m_valid;
    logic [DATA_W-1:0] r_top;
    logic [DW-1:0]     r_out_depth;
    t_status           r_out_st;

    logic [DW-1:0]     dm1, dm2;
    logic              has1, has2, full, shift_big;
    logic [DATA_W-1:0] n_res, ia, ib, neg_y, neg_x, res_sx;
    t_status           n_st;
    logic              need_iter;
    t_imode            imode;
    logic              it_done;
    logic [DATA_W-1:0] it_quo, it_rem;
    logic              we;
    logic [AW-1:0]     wa, ra;
    logic [DATA_W-1:0] wd;
    logic [DW-1:0]     n_depth;
    logic              upd_last, upd_saved;

    assign dm1  = r_depth - DW'(1);
    assign dm2  = r_depth - DW'(2);
    assign has1 = r_depth != '0;
    assign has2 = r_depth >= DW'(2);
    assign full = r_depth >= DW'(STACK_ENTRIES);
    assign ra   = i_cmd.rd_second ? dm2[AW-1:0] : dm1[AW-1:0];

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rdata <= r_mem[ra];
    end

    // Width register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcode <= WC_RESET;
        end else if (i_cfg_we) begin
            r_wcode <= i_cfg_wdata;
        end
    end

    // Item capture and operand reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_s_tdata[OP_W-1:0];
            r_val  <= i_s_tdata[OP_W+DATA_W-1:OP_W];
            r_slot <= (i_s_tdata[IN_W-2:IN_W-3] > SLOT_LAST) ? SLOT_LAST
                                                             : i_s_tdata[IN_W-2:IN_W-3];
        end
        if (i_cmd.cap_x) begin
            r_x <= sx(r_rdata, r_wcode);
        end
        if (i_cmd.cap_y) begin
            r_y <= sx(r_rdata, r_wcode);
        end
    end

    assign neg_y     = DATA_W'(0) - r_y;
    assign neg_x     = DATA_W'(0) - r_x;
    assign shift_big = (r_x[DATA_W-1:7] != '0) || (r_x[6:0] >= width_bits(r_wcode));

    // Operation decode: result word, status and whether the iterative unit is needed.
    always_comb begin
        n_res     = has1 ? r_x : '0;
        n_st      = ST_OK;
        need_iter = 1'b0;
        imode     = IM_MUL;
        ia        = r_y;
        ib        = r_x;
        case (r_op) inside
            [OP_ADD:OP_XOR]: begin
                if (!has2) begin
                    n_st = ST_FEW;
                end else begin
                    case (r_op)
                        OP_ADD: n_res = r_y + r_x;
                        OP_SUB: n_res = r_y - r_x;
                        OP_MUL: need_iter = 1'b1;
                        OP_DIV, OP_REM: begin
                            if (r_x == '0) begin
                                n_st = ST_DIV0;
                            end else if (&r_x) begin
                                n_res = (r_op == OP_DIV) ? neg_y : '0;
                            end else begin
                                need_iter = 1'b1;
                                imode     = IM_DIV;
                                ia        = r_y[DATA_W-1] ? neg_y : r_y;
                                ib        = r_x[DATA_W-1] ? neg_x : r_x;
                            end
                        end
                        OP_SHR: n_res = shift_big ? {DATA_W{r_y[DATA_W-1]}}
                                                  : DATA_W'($signed(r_y) >>> r_x[5:0]);
                        OP_SHL: n_res = shift_big ? '0 : (r_y << r_x[5:0]);
                        OP_AND: n_res = r_y & r_x;
                        OP_OR:  n_res = r_y | r_x;
                        default: n_res = r_y ^ r_x;
                    endcase
                end
            end
            [OP_NOT:OP_INT]: begin
                if (!has1) begin
                    n_st = ST_FEW;
                end else begin
                    case (r_op)
                        OP_NOT: n_res = ~r_x;
                        OP_NEG: n_res = neg_x;
                        OP_RECIP: begin
                            if (r_x == '0) begin
                                n_st = ST_DIV0;
                            end else if (r_x == DATA_W'(1) || (&r_x)) begin
                                n_res = r_x;
                            end else begin
                                n_res = '0;
                            end
                        end
                        OP_SQRT: begin
                            if (r_x[DATA_W-1]) begin
                                n_st = ST_NEGROOT;
                            end else begin
                                need_iter = 1'b1;
                                imode     = IM_SQRT;
                                ia        = r_x;
                            end
                        end
                        OP_FRAC: n_res = '0;
                        default: n_res = r_x;
                    endcase
                end
            end
            OP_PUSH, OP_LASTX, OP_RECALL: begin
                if (full) begin
                    n_st = ST_FULL;
                end else if (r_op == OP_PUSH) begin
                    n_res = r_val;
                end else if (r_op == OP_LASTX) begin
                    n_res = r_last_x;
                end else begin
                    n_res = r_saved[r_slot];
                end
            end
            OP_DUP: begin
                if (!has1) begin
                    n_st = ST_FEW;
                end else if (full) begin
                    n_st = ST_FULL;
                end
            end
            OP_CLEAR: begin
                if (!has1) n_st = ST_FEW;
                else       n_res = '0;
            end
            OP_DROP: begin
                if (!has1) n_st = ST_FEW;
                else       n_res = has2 ? r_y : '0;
            end
            OP_SWAP: begin
                if (!has2) n_st = ST_FEW;
                else       n_res = r_y;
            end
            OP_STORE: begin
                if (!has1) n_st = ST_FEW;
            end
            default: begin
            end
        endcase
    end

    irsa_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.oper && need_iter),
        .i_mode  (imode),
        .i_a     (ia),
        .i_b     (ib),
        .o_done  (it_done),
        .o_quo   (it_quo),
        .o_rem   (it_rem)
    );

    // Result register, from the decode or from the iterative unit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.oper) begin
            r_res  <= n_res;
            r_st   <= n_st;
            r_qneg <= r_y[DATA_W-1] ^ r_x[DATA_W-1];
            r_rneg <= r_y[DATA_W-1];
        end else if (i_cmd.iter_latch) begin
            case (r_op)
                OP_DIV:  r_res <= r_qneg ? (DATA_W'(0) - it_quo) : it_quo;
                OP_REM:  r_res <= r_rneg ? (DATA_W'(0) - it_rem) : it_rem;
                default: r_res <= it_quo;
            endcase
        end
    end

    assign res_sx = sx(r_res, r_wcode);

    // Write-back decode.
    always_comb begin
        we        = 1'b0;
        wa        = dm1[AW-1:0];
        wd        = res_sx;
        n_depth   = r_depth;
        upd_last  = 1'b0;
        upd_saved = 1'b0;
        if (i_cmd.swap2) begin
            we = 1'b1;
            wa = dm2[AW-1:0];
            wd = r_x;
        end else if (i_cmd.commit && r_st == ST_OK) begin
            case (r_op) inside
                [OP_ADD:OP_XOR]: begin
                    we       = 1'b1;
                    wa       = dm2[AW-1:0];
                    n_depth  = dm1;
                    upd_last = 1'b1;
                end
                [OP_NOT:OP_INT]: begin
                    we       = 1'b1;
                    upd_last = 1'b1;
                end
                OP_PUSH, OP_DUP, OP_LASTX, OP_RECALL: begin
                    we      = 1'b1;
                    wa      = r_depth[AW-1:0];
                    n_depth = r_depth + DW'(1);
                end
                OP_CLEAR: begin
                    n_depth  = '0;
                    upd_last = 1'b1;
                end
                OP_DROP: begin
                    n_depth  = dm1;
                    upd_last = 1'b1;
                end
                OP_SWAP:  we = 1'b1;
                OP_STORE: upd_saved = 1'b1;
                default: begin
                end
            endcase
        end
    end

    // Architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= '0;
            r_last_x   <= '0;
            r_saved[0] <= '0;
            r_saved[1] <= '0;
            r_saved[2] <= '0;
        end else begin
            r_depth <= n_depth;
            if (upd_last) begin
                r_last_x <= r_x;
            end
            if (upd_saved) begin
                r_saved[r_slot] <= r_x;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_top       <= res_sx;
            r_out_depth <= n_depth;
            r_out_st    <= r_st;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_top      = r_top;
    assign o_depth    = r_out_depth;
    assign o_status   = r_out_st;

    assign o_sts.need_iter = need_iter;
    assign o_sts.iter_done = it_done;
    assign o_sts.out_free  = !r_m_valid || i_m_tready;
    assign o_sts.swap_ok   = (r_op == OP_SWAP) && (r_st == ST_OK);

endmodule

FILE: design/irsa_checker.sv
// Port-level checker for the integer RPN stack ALU and its bind statement.
module irsa_checker import irsa_pkg::*; #(
    parameter int STACK_ENTRIES = 32
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [((DATA_W+$clog2(STACK_ENTRIES+1)+ST_W+7)/8)*8-1:0] m_tdata
);

    localparam int DW = $clog2(STACK_ENTRIES + 1);

    // No result word straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result word valid after reset");

    // One item at a time: input closes after a word is taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still open after accepting a word");

    // Reported depth never exceeds the stack size.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[DATA_W+DW-1:DATA_W] <= DW'(STACK_ENTRIES)))
        else $error("depth beyond stack size");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

endmodule

bind integer_rpn_stack_alu irsa_checker #(.STACK_ENTRIES(STACK_ENTRIES)) u_irsa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
